// File: sv/lpcf_pkg.sv
// ----------------------------------------------------------------------------
// lpcf_pkg: shared types and constants of the lidar point crop filter
// Point, configuration and stage payload structs, register indexes, reasons.
// ----------------------------------------------------------------------------
package lpcf_pkg;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 31;
   localparam int TAN_W         = 27;
   localparam int TAN_FRAC_BITS = 16;
   localparam int LHS_W         = 33 + TAN_FRAC_BITS;
   localparam int PROD_W        = TAN_W + 32;
   localparam int SQ_W          = 63;
   localparam int D2_W          = 64;
   localparam int RANGE_W       = 31;
   localparam int RANGE_SQ_W    = 2 * RANGE_W;
   localparam int INT_N_W       = 24;
   localparam int INT_RECIP_W   = 26;
   localparam int INT_PROD_W    = INT_N_W + INT_RECIP_W;
   localparam int INT_SHIFT     = 32;
   localparam int INT_W         = 18;
   localparam int REQ_DATA_W    = 120;
   localparam int RSP_DATA_W    = 120;
   localparam int RSP_USER_W    = 3;

   localparam logic [17:0]              FAR_LIMIT_M2 = 18'd250000;
   localparam logic [INT_N_W-1:0]       INT_ROUND    = 24'd50;
   // ceil(2^32 / 100): exact floor division by 100 for 24-bit numerators
   localparam logic [INT_RECIP_W-1:0]   INT_RECIP    = 26'd42949673;
   localparam logic signed [TAN_W-1:0]  TAN_LIMIT    = 27'sd37549300;
   localparam logic [RANGE_W-1:0]       RANGE_MAX    = 31'h7fffffff;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_INCLUDE_MASK = 3'd0,
      CSR_MIN_TAN_H    = 3'd1,
      CSR_MAX_TAN_H    = 3'd2,
      CSR_MIN_TAN_V    = 3'd3,
      CSR_MAX_TAN_V    = 3'd4,
      CSR_MIN_RANGE    = 3'd5,
      CSR_MAX_RANGE    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      REASON_KEEP = 2'd0,
      REASON_FLAG = 2'd1,
      REASON_FAR  = 2'd2,
      REASON_VIEW = 2'd3
   } reason_type;

   typedef struct packed {
      logic valid;
      logic load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [7:0]         reflectivity;
      logic [15:0]        point_flags;
      logic               frame_last;
   } point_type;

   typedef struct packed {
      logic [15:0]              include_mask;
      logic signed [TAN_W-1:0]  min_tan_h;
      logic signed [TAN_W-1:0]  max_tan_h;
      logic signed [TAN_W-1:0]  min_tan_v;
      logic signed [TAN_W-1:0]  max_tan_v;
      logic [RANGE_SQ_W-1:0]    min_sq;
      logic [RANGE_SQ_W-1:0]    max_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0]       out_x;
      logic signed [32:0]       out_y;
      logic signed [31:0]       out_z;
      logic                     last;
      logic                     flag_fail;
      logic [SQ_W-1:0]          sq_x;
      logic [SQ_W-1:0]          sq_y;
      logic [SQ_W-1:0]          sq_z;
      logic signed [LHS_W-1:0]  lhs_h;
      logic signed [LHS_W-1:0]  lhs_v;
      logic signed [PROD_W-1:0] plo_h;
      logic signed [PROD_W-1:0] phi_h;
      logic signed [PROD_W-1:0] plo_v;
      logic signed [PROD_W-1:0] phi_v;
      logic                     den_zero;
      logic                     den_neg;
      logic                     num_h_zero;
      logic                     num_v_zero;
      logic [INT_PROD_W-1:0]    int_prod;
   } mul_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [32:0] out_y;
      logic signed [31:0] out_z;
      logic               last;
      logic               flag_fail;
      logic [D2_W-1:0]    d2;
      logic               view_ok;
      logic [INT_W-1:0]   intensity;
   } cmp_type;

endpackage

// File: sv/lpcf_cfg.sv
// ----------------------------------------------------------------------------
// lpcf_cfg: configuration registers
// Holds the filter limits and keeps registered squares of the range limits.
// ----------------------------------------------------------------------------
module lpcf_cfg
   import lpcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [15:0]             mask_ff;
   logic signed [TAN_W-1:0] min_tan_h_ff;
   logic signed [TAN_W-1:0] max_tan_h_ff;
   logic signed [TAN_W-1:0] min_tan_v_ff;
   logic signed [TAN_W-1:0] max_tan_v_ff;
   logic [RANGE_W-1:0]      min_range_ff;
   logic [RANGE_W-1:0]      max_range_ff;
   logic [RANGE_SQ_W-1:0]   min_sq_ff;
   logic [RANGE_SQ_W-1:0]   max_sq_ff;
   logic [RANGE_SQ_W-1:0]   min_sq_in;
   logic [RANGE_SQ_W-1:0]   max_sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         min_tan_h_ff <= -TAN_LIMIT;
         max_tan_h_ff <= TAN_LIMIT;
         min_tan_v_ff <= -TAN_LIMIT;
         max_tan_v_ff <= TAN_LIMIT;
         min_range_ff <= '0;
         max_range_ff <= RANGE_MAX;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INCLUDE_MASK: mask_ff      <= csr_wdata[15:0];
            CSR_MIN_TAN_H:    min_tan_h_ff <= csr_wdata[TAN_W-1:0];
            CSR_MAX_TAN_H:    max_tan_h_ff <= csr_wdata[TAN_W-1:0];
            CSR_MIN_TAN_V:    min_tan_v_ff <= csr_wdata[TAN_W-1:0];
            CSR_MAX_TAN_V:    max_tan_v_ff <= csr_wdata[TAN_W-1:0];
            CSR_MIN_RANGE:    min_range_ff <= csr_wdata[RANGE_W-1:0];
            CSR_MAX_RANGE:    max_range_ff <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   assign min_sq_in = min_range_ff * min_range_ff;
   assign max_sq_in = max_range_ff * max_range_ff;

   // squares of the range limits are registered from the range registers
   always_ff @(posedge clock) begin
      min_sq_ff <= min_sq_in;
      max_sq_ff <= max_sq_in;
   end

   always_comb begin
      cfg.include_mask = mask_ff;
      cfg.min_tan_h    = min_tan_h_ff;
      cfg.max_tan_h    = max_tan_h_ff;
      cfg.min_tan_v    = min_tan_v_ff;
      cfg.max_tan_v    = max_tan_v_ff;
      cfg.min_sq       = min_sq_ff;
      cfg.max_sq       = max_sq_ff;
   end

endmodule

// File: sv/lpcf_mul.sv
// ----------------------------------------------------------------------------
// lpcf_mul: multiply stage
// Squares of the coordinates, tangent cross products, intensity reciprocal.
// ----------------------------------------------------------------------------
module lpcf_mul
   import lpcf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pipe_ctrl_type ctrl,
   input  cfg_type       cfg,
   input  point_type     pt,
   output logic          valid,
   output mul_type       res
);

   logic              valid_ff;
   mul_type           res_ff;
   mul_type           res_in;
   logic [31:0]       ux, uy, uz;
   logic [31:0]       mag_x, mag_y, mag_z;
   logic signed [32:0] neg_x;
   logic [INT_N_W-1:0] int_n;

   always_comb begin
      ux    = pt.pos_x;
      uy    = pt.pos_y;
      uz    = pt.pos_z;
      mag_x = ux[31] ? (~ux + 32'd1) : ux;
      mag_y = uy[31] ? (~uy + 32'd1) : uy;
      mag_z = uz[31] ? (~uz + 32'd1) : uz;
      neg_x = -(33'(pt.pos_x));
      int_n = {pt.reflectivity, 16'h0000} + INT_ROUND;

      res_in.out_x      = pt.pos_y;
      res_in.out_y      = neg_x;
      res_in.out_z      = pt.pos_z;
      res_in.last       = pt.frame_last;
      res_in.flag_fail  = |(pt.point_flags & ~cfg.include_mask);
      res_in.sq_x       = mag_x * mag_x;
      res_in.sq_y       = mag_y * mag_y;
      res_in.sq_z       = mag_z * mag_z;
      // ratio numerators scaled to the Q16 tangent format, denominator is sensor y
      res_in.lhs_h      = {neg_x, {TAN_FRAC_BITS{1'b0}}};
      res_in.lhs_v      = {pt.pos_z[31], pt.pos_z, {TAN_FRAC_BITS{1'b0}}};
      res_in.plo_h      = cfg.min_tan_h * pt.pos_y;
      res_in.phi_h      = cfg.max_tan_h * pt.pos_y;
      res_in.plo_v      = cfg.min_tan_v * pt.pos_y;
      res_in.phi_v      = cfg.max_tan_v * pt.pos_y;
      res_in.den_zero   = (pt.pos_y == 32'sd0);
      res_in.den_neg    = pt.pos_y[31];
      res_in.num_h_zero = (pt.pos_x == 32'sd0);
      res_in.num_v_zero = (pt.pos_z == 32'sd0);
      res_in.int_prod   = int_n * INT_RECIP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         res_ff <= res_in;
      end
   end

   assign valid = valid_ff;
   assign res   = res_ff;

endmodule

// File: sv/lpcf_cmp.sv
// ----------------------------------------------------------------------------
// lpcf_cmp: compare stage
// Sums the squared range and checks both view tangents by cross product.
// ----------------------------------------------------------------------------
module lpcf_cmp
   import lpcf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pipe_ctrl_type ctrl,
   input  mul_type       mr,
   output logic          valid,
   output cmp_type       res
);

   logic    valid_ff;
   cmp_type res_ff;
   cmp_type res_in;
   logic    ok_h, ok_v;

   function automatic logic ratio_ok(
      input logic signed [LHS_W-1:0]  lhs,
      input logic signed [PROD_W-1:0] plo,
      input logic signed [PROD_W-1:0] phi,
      input logic                     den_zero,
      input logic                     den_neg,
      input logic                     num_zero
   );
      logic signed [PROD_W-1:0] lhs_ext;
      logic                     below, above;
      lhs_ext = PROD_W'(lhs);
      // negative denominator flips both comparisons
      below = den_neg ? (lhs_ext > plo) : (lhs_ext < plo);
      above = den_neg ? (lhs_ext < phi) : (lhs_ext > phi);
      // zero denominator: only a zero numerator passes
      return den_zero ? num_zero : (!below && !above);
   endfunction

   always_comb begin
      ok_h = ratio_ok(mr.lhs_h, mr.plo_h, mr.phi_h, mr.den_zero, mr.den_neg,
                      mr.num_h_zero);
      ok_v = ratio_ok(mr.lhs_v, mr.plo_v, mr.phi_v, mr.den_zero, mr.den_neg,
                      mr.num_v_zero);
      res_in.out_x     = mr.out_x;
      res_in.out_y     = mr.out_y;
      res_in.out_z     = mr.out_z;
      res_in.last      = mr.last;
      res_in.flag_fail = mr.flag_fail;
      res_in.d2        = D2_W'(mr.sq_x) + D2_W'(mr.sq_y) + D2_W'(mr.sq_z);
      res_in.view_ok   = ok_h && ok_v;
      res_in.intensity = mr.int_prod[INT_SHIFT +: INT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         res_ff <= res_in;
      end
   end

   assign valid = valid_ff;
   assign res   = res_ff;

endmodule

// File: sv/lpcf_out.sv
// ----------------------------------------------------------------------------
// lpcf_out: decision and output stage
// Range tests, reject reason priority and the registered result beat.
// ----------------------------------------------------------------------------
module lpcf_out
   import lpcf_pkg::*;
#(
   parameter int FRAC_BITS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   input  pipe_ctrl_type         ctrl,
   input  cfg_type               cfg,
   input  cmp_type               cr,
   output logic                  valid,
   output logic [RSP_DATA_W-1:0] tdata,
   output logic [RSP_USER_W-1:0] tuser,
   output logic                  tlast
);

   localparam int FarShift = 2 * FRAC_BITS;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] tdata_ff, tdata_in;
   logic [RSP_USER_W-1:0] tuser_ff, tuser_in;
   logic                  tlast_ff;
   logic                  far, range_ok, keep;
   reason_type            reason;

   always_comb begin
      far      = (cr.d2 >> FarShift) >= D2_W'(FAR_LIMIT_M2);
      range_ok = (cr.d2 >= D2_W'(cfg.min_sq)) && (cr.d2 <= D2_W'(cfg.max_sq));
      priority if (cr.flag_fail) begin
         reason = REASON_FLAG;
      end else if (far) begin
         reason = REASON_FAR;
      end else if (cr.view_ok && range_ok) begin
         reason = REASON_KEEP;
      end else begin
         reason = REASON_VIEW;
      end
      keep = (reason == REASON_KEEP);
      if (keep) begin
         tdata_in = {{(RSP_DATA_W - 115){1'b0}}, cr.intensity, cr.out_z, cr.out_y,
                     cr.out_x};
      end else begin
         tdata_in = '0;
      end
      tuser_in = {reason, keep};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         tdata_ff <= tdata_in;
         tuser_ff <= tuser_in;
         tlast_ff <= cr.last;
      end
   end

   assign valid = valid_ff;
   assign tdata = tdata_ff;
   assign tuser = tuser_ff;
   assign tlast = tlast_ff;

endmodule

// File: sv/lidar_point_crop_filter.sv
// ----------------------------------------------------------------------------
// lidar_point_crop_filter: lidar point region-of-interest filter
// Flag mask, far limit, view tangent and range tests; axis swap and intensity.
// ----------------------------------------------------------------------------
// Takes one point per clock while req_tready is high and returns one result
// beat per point, in order. The pipeline has four register stages (input,
// multiply, compare, decide), which a point passes through in that order; each
// stage advances whenever its successor has room, so a stalled output only
// holds the beats behind it and bubbles are squeezed out. The multiply stage
// (coordinate squares and the 27x32 tangent cross products) sets the clock.
// Rejected points return zero coordinates and intensity, with the reason in
// tuser. Range limits take effect once the range register and its square update.
module lidar_point_crop_filter
   import lpcf_pkg::*;
#(
   parameter int FRAC_BITS = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   // fields from bit 0: pos_x[31:0], pos_y[31:0], pos_z[31:0],
   // reflectivity[7:0], point_flags[15:0]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tlast,
   // fields from bit 0: out_x[31:0], out_y[32:0], out_z[31:0],
   // intensity[17:0], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // fields from bit 0: keep, reject_reason[1:0]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;
   point_type     pt_ff, pt_in;
   logic          v1_ff;
   logic          v2, v3, v4;
   logic          rdy1, rdy2, rdy3, rdy4;
   mul_type       mr;
   cmp_type       cr;
   pipe_ctrl_type ctrl2, ctrl3, ctrl4;

   lpcf_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ready ripples back from the output register
   assign rdy4       = !v4 || rsp_tready;
   assign rdy3       = !v3 || rdy4;
   assign rdy2       = !v2 || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_comb begin
      pt_in.pos_x        = req_tdata[31:0];
      pt_in.pos_y        = req_tdata[63:32];
      pt_in.pos_z        = req_tdata[95:64];
      pt_in.reflectivity = req_tdata[103:96];
      pt_in.point_flags  = req_tdata[119:104];
      pt_in.frame_last   = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pt_ff <= pt_in;
      end
   end

   assign ctrl2 = '{valid: v1_ff, load: rdy2};
   assign ctrl3 = '{valid: v2,    load: rdy3};
   assign ctrl4 = '{valid: v3,    load: rdy4};

   lpcf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl2),
      .cfg   (cfg),
      .pt    (pt_ff),
      .valid (v2),
      .res   (mr)
   );

   lpcf_cmp u_cmp (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl3),
      .mr    (mr),
      .valid (v3),
      .res   (cr)
   );

   lpcf_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl4),
      .cfg   (cfg),
      .cr    (cr),
      .valid (v4),
      .tdata (rsp_tdata),
      .tuser (rsp_tuser),
      .tlast (rsp_tlast)
   );

   assign rsp_tvalid = v4;

endmodule

// File: sv/lpcf_checker.sv
// ----------------------------------------------------------------------------
// lpcf_checker: port-level checks for the crop filter
// Result beat consistency, stall behavior and ready when no result is waiting.
// ----------------------------------------------------------------------------
module lpcf_checker
   import lpcf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_keep_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0] == (rsp_tuser[2:1] == REASON_KEEP))
      else $error("keep flag disagrees with reject reason");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("rejected point carries data");

   // with no result waiting every stage has room
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:115] == '0)
      else $error("result pad bits set");

endmodule

bind lidar_point_crop_filter lpcf_checker u_lpcf_checker (.*);

// File: verif/lidar_point_crop_filter_tb.sv
// ----------------------------------------------------------------------------
// lidar_point_crop_filter_tb: self-checking bench for the lidar crop filter
// Streams directed and random points under several register settings, with
// random gaps on both sides, and checks every result beat in order.
// ----------------------------------------------------------------------------
module lidar_point_crop_filter_tb
   import lpcf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 16;
   localparam int Q16_ONE      = 1 << TAN_FRAC_BITS;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int FAR_EDGE     = 500 * (1 << FRAC_BITS);
   localparam logic signed [31:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;
   // index past the end of the register list, writes to it must be dropped
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct {
      logic               keep;
      reason_type         reason;
      logic signed [31:0] out_x;
      logic signed [32:0] out_y;
      logic signed [31:0] out_z;
      logic [INT_W-1:0]   intensity;
      logic               frame_end;
   } crop_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tlast = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the filter registers, reset values
   logic [15:0]             allowed_flags = '0;
   logic signed [TAN_W-1:0] tan_lo_h = -TAN_LIMIT;
   logic signed [TAN_W-1:0] tan_hi_h = TAN_LIMIT;
   logic signed [TAN_W-1:0] tan_lo_v = -TAN_LIMIT;
   logic signed [TAN_W-1:0] tan_hi_v = TAN_LIMIT;
   logic [RANGE_W-1:0]      range_lo = '0;
   logic [RANGE_W-1:0]      range_hi = RANGE_MAX;

   point_type       points_to_send[$];
   crop_result_type pending_crops[$];
   bit              steady = 1'b0;
   int              mismatches = 0;
   int              stall_cycles = 0;

   lidar_point_crop_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // lo <= num/den <= hi with Q11.16 limits; a zero divisor passes only 0/0
   function automatic bit ratio_within(longint num, longint den, longint lo, longint hi);
      longint scaled;
      if (den == 0) return num == 0;
      scaled = num * Q16_ONE;
      if (den > 0) return scaled >= lo * den && scaled <= hi * den;
      return scaled <= lo * den && scaled >= hi * den;
   endfunction

   function automatic crop_result_type crop_point(point_type p);
      crop_result_type r;
      longint          sx, sy, sz;
      logic [65:0]     mx, my, mz, d2, lo_sq, hi_sq;
      bit              in_view;
      sx = p.pos_x;
      sy = p.pos_y;
      sz = p.pos_z;
      mx = 66'((sx < 0) ? -sx : sx);
      my = 66'((sy < 0) ? -sy : sy);
      mz = 66'((sz < 0) ? -sz : sz);
      d2 = mx * mx + my * my + mz * mz;
      lo_sq = 66'(range_lo);
      lo_sq = lo_sq * lo_sq;
      hi_sq = 66'(range_hi);
      hi_sq = hi_sq * hi_sq;
      // output frame: x = sensor y, y = -sensor x, z = sensor z
      in_view = ratio_within(-sx, sy, tan_lo_h, tan_hi_h)
             && ratio_within(sz, sy, tan_lo_v, tan_hi_v)
             && d2 >= lo_sq && d2 <= hi_sq;
      if ((p.point_flags & ~allowed_flags) != 0) r.reason = REASON_FLAG;
      else if ((d2 >> (2 * FRAC_BITS)) >= FAR_LIMIT_M2) r.reason = REASON_FAR;
      else if (!in_view) r.reason = REASON_VIEW;
      else r.reason = REASON_KEEP;
      r.keep = (r.reason == REASON_KEEP);
      r.frame_end = p.frame_last;
      if (r.keep) begin
         r.out_x = 32'(sy);
         r.out_y = 33'(-sx);
         r.out_z = 32'(sz);
         r.intensity = INT_W'((32'(p.reflectivity) * Q16_ONE + 50) / 100);
      end else begin
         r.out_x = '0;
         r.out_y = '0;
         r.out_z = '0;
         r.intensity = '0;
      end
      return r;
   endfunction

   task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic [7:0] refl,
                            logic [15:0] flags, logic last);
      point_type p;
      p.pos_x = x;
      p.pos_y = y;
      p.pos_z = z;
      p.reflectivity = refl;
      p.point_flags = flags;
      p.frame_last = last;
      points_to_send.push_back(p);
   endtask

   function automatic logic signed [31:0] random_coord(int unsigned scale);
      logic [31:0] v;
      v = $urandom;
      unique case (scale)
         0: return v;
         1: return $signed(v) >>> 6;
         2: return $signed(v) >>> 9;
         3: return $signed(v) >>> 14;
         default: return $signed(v) >>> 24;
      endcase
   endfunction

   function automatic point_type random_point();
      point_type          p;
      int unsigned        pick, scale;
      logic signed [31:0] ys;
      longint             tan_h, tan_v;
      pick = $urandom_range(0, 99);
      scale = (pick < 10) ? 0 : (pick < 25) ? 1 : (pick < 60) ? 2 : (pick < 85) ? 3 : 4;
      p.pos_x = random_coord(scale);
      p.pos_y = random_coord(scale);
      p.pos_z = random_coord(scale);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         p.pos_x = '0;
      end else if (pick < 16) begin
         p.pos_y = '0;
      end else if (pick < 20) begin
         p.pos_z = '0;
      end else if (pick < 24) begin
         p.pos_x = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         p.pos_y = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         p.pos_z = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end else if (pick < 36) begin
         // land on or right next to the configured view edges
         ys = random_coord(4);
         if (ys == 0) ys = 1;
         tan_h = $urandom_range(0, 1) ? tan_hi_h : tan_lo_h;
         tan_v = $urandom_range(0, 1) ? tan_hi_v : tan_lo_v;
         p.pos_y = ys;
         p.pos_x = 32'(-((longint'(ys) * tan_h) >>> TAN_FRAC_BITS)
                       + longint'($urandom_range(0, 2)) - 1);
         p.pos_z = 32'(((longint'(ys) * tan_v) >>> TAN_FRAC_BITS)
                       + longint'($urandom_range(0, 2)) - 1);
      end
      p.reflectivity = 8'($urandom_range(0, 255));
      p.point_flags = ($urandom_range(0, 3) != 0) ? 16'($urandom) & allowed_flags
                                                  : 16'($urandom);
      p.frame_last = ($urandom_range(0, 15) == 0);
      return p;
   endfunction

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      unique case (idx)
         CSR_INCLUDE_MASK: allowed_flags = value[15:0];
         CSR_MIN_TAN_H:    tan_lo_h = value[TAN_W-1:0];
         CSR_MAX_TAN_H:    tan_hi_h = value[TAN_W-1:0];
         CSR_MIN_TAN_V:    tan_lo_v = value[TAN_W-1:0];
         CSR_MAX_TAN_V:    tan_hi_v = value[TAN_W-1:0];
         CSR_MIN_RANGE:    range_lo = value;
         CSR_MAX_RANGE:    range_hi = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [15:0] mask, int min_h, int max_h, int min_v,
                               int max_v, logic [RANGE_W-1:0] rmin,
                               logic [RANGE_W-1:0] rmax);
      write_csr(CSR_INCLUDE_MASK, CSR_DATA_W'(mask));
      write_csr(CSR_MIN_TAN_H, CSR_DATA_W'(min_h));
      write_csr(CSR_MAX_TAN_H, CSR_DATA_W'(max_h));
      write_csr(CSR_MIN_TAN_V, CSR_DATA_W'(min_v));
      write_csr(CSR_MAX_TAN_V, CSR_DATA_W'(max_v));
      write_csr(CSR_MIN_RANGE, rmin);
      write_csr(CSR_MAX_RANGE, rmax);
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      int                 a, b, c, d, t;
      logic [RANGE_W-1:0] r0, r1, rt;
      int unsigned        pick;
      a = int'($urandom_range(0, 2 * TAN_LIMIT)) - TAN_LIMIT;
      b = int'($urandom_range(0, 2 * TAN_LIMIT)) - TAN_LIMIT;
      c = int'($urandom_range(0, 2 * TAN_LIMIT)) - TAN_LIMIT;
      d = int'($urandom_range(0, 2 * TAN_LIMIT)) - TAN_LIMIT;
      // mostly ordered limits, now and then crossed ones
      if (a > b && $urandom_range(0, 9) != 0) begin t = a; a = b; b = t; end
      if (c > d && $urandom_range(0, 9) != 0) begin t = c; c = d; d = t; end
      if ($urandom_range(0, 9) == 0) begin a = -TAN_LIMIT; b = TAN_LIMIT; end
      r0 = RANGE_W'($urandom_range(0, 8 * Q16_ONE));
      pick = $urandom_range(0, 99);
      if (pick < 15) r1 = RANGE_MAX;
      else if (pick < 25) r1 = RANGE_W'($urandom);
      else r1 = RANGE_W'(r0 + $urandom_range(0, 400 * Q16_ONE));
      if ($urandom_range(0, 9) == 0) begin rt = r0; r0 = r1; r1 = rt; end
      apply_config(($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom),
                   a, b, c, d, r0, r1);
   endtask

   // wait until the pipeline is empty, then let it settle
   task automatic settle();
      do @(negedge clock);
      while (points_to_send.size() != 0 || req_tvalid || pending_crops.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : driver
      point_type taken, next_pt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.pos_x = req_tdata[31:0];
            taken.pos_y = req_tdata[63:32];
            taken.pos_z = req_tdata[95:64];
            taken.reflectivity = req_tdata[103:96];
            taken.point_flags = req_tdata[119:104];
            taken.frame_last = req_tlast;
            pending_crops.push_back(crop_point(taken));
         end
         if (!req_tvalid || req_tready) begin
            if (points_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
               next_pt = points_to_send.pop_front();
               req_tdata <= {next_pt.point_flags, next_pt.reflectivity,
                             next_pt.pos_z, next_pt.pos_y, next_pt.pos_x};
               req_tlast <= next_pt.frame_last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      crop_result_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // tdata: out_x 31:0, out_y 64:32, out_z 96:65, intensity 114:97
            seen.out_x = rsp_tdata[31:0];
            seen.out_y = rsp_tdata[64:32];
            seen.out_z = rsp_tdata[96:65];
            seen.intensity = rsp_tdata[114:97];
            seen.keep = rsp_tuser[0];
            seen.reason = reason_type'(rsp_tuser[2:1]);
            seen.frame_end = rsp_tlast;
            if (pending_crops.size() == 0) begin
               $error("result beat with no point outstanding");
               mismatches++;
            end else begin
               want = pending_crops.pop_front();
               check_field("keep", want.keep, seen.keep);
               check_field("reject_reason", want.reason, seen.reason);
               check_field("out_x", want.out_x, seen.out_x);
               check_field("out_y", want.out_y, seen.out_y);
               check_field("out_z", want.out_z, seen.out_z);
               check_field("intensity", want.intensity, seen.intensity);
               check_field("frame_end", want.frame_end, seen.frame_end);
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults: origin, zero divisors, flag and far priority
      add_point(0, 0, 0, 8'd0, 16'h0000, 1'b0);
      add_point(0, 65536, 0, 8'd255, 16'h0000, 1'b1);
      add_point(65536, 0, 0, 8'd50, 16'h0000, 1'b0);
      add_point(0, 0, 65536, 8'd1, 16'h0000, 1'b0);
      add_point(0, 65536, 0, 8'd100, 16'hffff, 1'b1);
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'd255, 16'hffff, 1'b0);
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'd255, 16'h0000, 1'b0);
      add_point(COORD_MIN, COORD_MIN, COORD_MIN, 8'd7, 16'h0000, 1'b1);
      add_point(0, FAR_EDGE, 0, 8'd99, 16'h0000, 1'b0);
      add_point(0, FAR_EDGE - 1, 0, 8'd99, 16'h0000, 1'b0);
      // steepest default tangent: 572 inside, 573 outside
      add_point(-572, 1, 0, 8'd3, 16'h0000, 1'b0);
      add_point(-573, 1, 0, 8'd3, 16'h0000, 1'b0);
      add_point(0, -1, 573, 8'd3, 16'h0000, 1'b1);
      settle();

      // unit tangent, half vertical tangent, 1 m to 100 m
      apply_config(16'h00ff, -65536, 65536, -32768, 32768, 31'(Q16_ONE),
                   31'(100 * Q16_ONE));
      add_point(-65536, 65536, 0, 8'd10, 16'h00ff, 1'b0);
      add_point(-65537, 65536, 0, 8'd10, 16'h0000, 1'b0);
      add_point(65536, -65536, 0, 8'd20, 16'h0001, 1'b0);
      add_point(0, 65536, 32768, 8'd30, 16'h0080, 1'b0);
      add_point(0, 65535, 0, 8'd40, 16'h0000, 1'b0);
      add_point(0, 100 * Q16_ONE, 0, 8'd60, 16'h0000, 1'b0);
      add_point(0, 100 * Q16_ONE + 1, 0, 8'd70, 16'h0000, 1'b1);
      add_point(0, 65536, 0, 8'd80, 16'h0100, 1'b0);
      settle();

      // horizontal limits crossed
      apply_config(16'hffff, TAN_LIMIT, -TAN_LIMIT, -TAN_LIMIT, TAN_LIMIT, '0, RANGE_MAX);
      add_point(0, 65536, 0, 8'd5, 16'h8000, 1'b0);
      add_point(0, 0, 0, 8'd5, 16'h0000, 1'b1);
      settle();

      // range limits crossed
      apply_config(16'h0000, -TAN_LIMIT, TAN_LIMIT, -TAN_LIMIT, TAN_LIMIT, RANGE_MAX, '0);
      add_point(0, 65536, 0, 8'd5, 16'h0000, 1'b0);
      settle();

      // degenerate windows at the tangent extremes, zero range only
      apply_config(16'hffff, TAN_LIMIT, TAN_LIMIT, -TAN_LIMIT, -TAN_LIMIT, '0, '0);
      add_point(0, 0, 0, 8'd200, 16'h5555, 1'b1);
      settle();

      for (int phase = 0; phase < 7; phase++) begin
         random_config();
         steady = (phase == 3);
         repeat (steady ? 200 : 100) points_to_send.push_back(random_point());
         settle();
      end
      steady = 1'b0;

      if (mismatches == 0 && pending_crops.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
sv/lpcf_pkg.sv
sv/lpcf_cfg.sv
sv/lpcf_mul.sv
sv/lpcf_cmp.sv
sv/lpcf_out.sv
sv/lidar_point_crop_filter.sv
sv/lpcf_checker.sv
verif/lidar_point_crop_filter_tb.sv
